[hw/rtl/tevq_pkg.sv]
// Shared types and constants of the timed event queue.
// No dependencies; every other file imports this package.
`default_nettype none

package tevq_pkg;

  localparam int unsigned QueueDepth = 64;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CntW       = AddrW + 1;

  localparam int unsigned TimeW = 32;
  localparam int unsigned TypeW = 3;
  localparam int unsigned PortW = 16;
  localparam int unsigned TolW  = 16;
  localparam int unsigned StatW = 3;
  localparam int unsigned OccW  = 7;
  localparam int unsigned PosW  = 6;
  localparam int unsigned CmdW  = 2;

  typedef enum logic [CmdW-1:0] {
    CmdInsert = 2'd0,
    CmdPop    = 2'd1,
    CmdDelete = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    StPlaced  = 3'd0,
    StScan    = 3'd1,
    StDup     = 3'd2,
    StNoPlace = 3'd3,
    StFull    = 3'd4,
    StEmpty   = 3'd5,
    StBadPos  = 3'd6
  } status_e;

  // event kind codes used by the tie rules
  localparam logic [TypeW-1:0] EvTy0 = 3'd0;
  localparam logic [TypeW-1:0] EvTy1 = 3'd1;
  localparam logic [TypeW-1:0] EvTy2 = 3'd2;
  localparam logic [TypeW-1:0] EvTy3 = 3'd3;
  localparam logic [TypeW-1:0] EvTy4 = 3'd4;

  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [TypeW-1:0] ev_type;
    logic [PortW-1:0] ev_port;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_e          status;
    logic             out_valid;
    entry_t           popped;
    logic [OccW-1:0]  occupancy;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/tevq_if.sv]
// Channel interfaces of the timed event queue: command beats in, result beats out.
// Depends on tevq_pkg.
`default_nettype none

interface tevq_in_if;
  import tevq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  cmd;
  logic [TimeW-1:0] event_time;
  logic [TypeW-1:0] event_type;
  logic [PortW-1:0] event_port;
  logic [PosW-1:0]  position;

  modport source (output valid, cmd, event_time, event_type, event_port, position,
                  input ready);
  modport sink   (input valid, cmd, event_time, event_type, event_port, position,
                  output ready);
endinterface

interface tevq_out_if;
  import tevq_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic             out_valid;
  logic [TimeW-1:0] out_time;
  logic [TypeW-1:0] out_type;
  logic [PortW-1:0] out_port;
  logic [OccW-1:0]  occupancy;

  modport source (output valid, status, out_valid, out_time, out_type, out_port, occupancy,
                  input ready);
  modport sink   (input valid, status, out_valid, out_time, out_type, out_port, occupancy,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/tevq_mem.sv]
// Slot store of the event queue: one write port, one read port, registered read data.
// Depends on tevq_pkg.
`default_nettype none

module tevq_mem (
  input  logic                clk_i,
  input  tevq_pkg::mem_req_t  req_i,
  output tevq_pkg::entry_t    rdata_o
);
  import tevq_pkg::*;

  entry_t mem_q [QueueDepth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/tevq_ctrl.sv]
// Command sequencer: head/tail checks, tie scan and shift passes over the slot store.
// Depends on tevq_pkg and tevq_in_if; drives tevq_mem.
`default_nettype none

module tevq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [tevq_pkg::TolW-1:0] tol_i,
  tevq_in_if.sink             evt_i,
  output tevq_pkg::mem_req_t  mem_req_o,
  input  tevq_pkg::entry_t    mem_rdata_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output tevq_pkg::res_t      res_o
);
  import tevq_pkg::*;

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SHead  = 9'b000000010,
    STail  = 9'b000000100,
    SScan  = 9'b000001000,
    SShUp  = 9'b000010000,
    SWrite = 9'b000100000,
    SPopRd = 9'b001000000,
    SShDn  = 9'b010000000,
    SFin   = 9'b100000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  k_q, k_d;
  logic [CntW-1:0]  p_q, p_d;
  logic [CntW-1:0]  i_q, i_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] pend_addr_q, pend_addr_d;
  logic             rd_done_q, rd_done_d;
  entry_t           cur_q, cur_d;
  entry_t           ev_q, ev_d;
  entry_t           pop_q, pop_d;
  logic             popv_q, popv_d;
  status_e          st_q, st_d;

  logic             go_up, go_down;
  logic [CntW-1:0]  up_p, down_s;
  logic             has_next, near, x_later, e_earlier, before_rule;
  logic [TimeW-1:0] diff;
  entry_t           x;
  mem_req_t         req;

  // scan compare terms
  assign x         = mem_rdata_i;
  assign has_next  = (i_q + CntW'(1)) < cnt_q;
  assign diff      = (cur_q.ev_time > ev_q.ev_time) ? (cur_q.ev_time - ev_q.ev_time)
                                                    : (ev_q.ev_time - cur_q.ev_time);
  assign near      = diff < {{(TimeW-TolW){1'b0}}, tol_i};
  assign x_later   = x.ev_time > ev_q.ev_time;
  assign e_earlier = cur_q.ev_time < ev_q.ev_time;
  assign before_rule = (ev_q.ev_type == EvTy4) || (ev_q.ev_type == EvTy0) ||
                       ((ev_q.ev_type == EvTy2) && (cur_q.ev_type != EvTy0)) ||
                       ((ev_q.ev_type == EvTy1) && (cur_q.ev_type == EvTy3));

  assign evt_i.ready = (state_q == SIdle);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    p_d         = p_q;
    i_d         = i_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    rd_done_d   = rd_done_q;
    cur_d       = cur_q;
    ev_d        = ev_q;
    pop_d       = pop_q;
    popv_d      = popv_q;
    st_d        = st_q;
    req         = '0;
    go_up       = 1'b0;
    go_down     = 1'b0;
    up_p        = '0;
    down_s      = '0;

    unique case (state_q)
      SIdle: begin
        if (evt_i.valid) begin
          ev_d   = '{ev_time: evt_i.event_time, ev_type: evt_i.event_type,
                     ev_port: evt_i.event_port};
          pop_d  = '0;
          popv_d = 1'b0;
          st_d   = StPlaced;
          unique case (cmd_e'(evt_i.cmd))
            CmdInsert: begin
              if (cnt_q >= CntW'(QueueDepth)) begin
                st_d    = StFull;
                state_d = SFin;
              end else if (cnt_q == '0) begin
                p_d     = '0;
                state_d = SWrite;
              end else begin
                req.re   = 1'b1;
                req.raddr = '0;
                state_d  = SHead;
              end
            end
            CmdPop: begin
              if (cnt_q == '0) begin
                st_d    = StEmpty;
                state_d = SFin;
              end else begin
                req.re    = 1'b1;
                req.raddr = '0;
                state_d   = SPopRd;
              end
            end
            CmdDelete: begin
              if (cnt_q == '0) begin
                st_d    = StEmpty;
                state_d = SFin;
              end else if ((PosW+CntW)'(evt_i.position) >= (PosW+CntW)'(cnt_q)) begin
                st_d    = StBadPos;
                state_d = SFin;
              end else begin
                go_down = 1'b1;
                down_s  = CntW'(evt_i.position) + CntW'(1);
              end
            end
            default: state_d = SFin;
          endcase
        end
      end

      SHead: begin
        cur_d = mem_rdata_i;
        if (mem_rdata_i.ev_time > ev_q.ev_time) begin
          go_up = 1'b1;
          up_p  = '0;
        end else begin
          req.re    = 1'b1;
          req.raddr = AddrW'(cnt_q - CntW'(1));
          state_d   = STail;
        end
      end

      STail: begin
        if (mem_rdata_i.ev_time < ev_q.ev_time) begin
          go_up = 1'b1;
          up_p  = cnt_q;
        end else begin
          i_d       = '0;
          req.re    = 1'b1;
          req.raddr = AddrW'(1);
          state_d   = SScan;
        end
      end

      SScan: begin
        if (has_next && ((e_earlier && x_later) || (x_later && near))) begin
          st_d  = StScan;
          go_up = 1'b1;
          up_p  = i_q + CntW'(1);
        end else if (near && (cur_q.ev_type == ev_q.ev_type)) begin
          if ((ev_q.ev_type == EvTy0) || (ev_q.ev_type == EvTy1) ||
              (ev_q.ev_type == EvTy3)) begin
            st_d    = StDup;
            state_d = SFin;
          end else begin
            st_d  = StScan;
            go_up = 1'b1;
            up_p  = i_q + CntW'(1);
          end
        end else if (near && before_rule) begin
          st_d  = StScan;
          go_up = 1'b1;
          up_p  = i_q;
        end else if (near && ((ev_q.ev_type == EvTy1) || (ev_q.ev_type == EvTy3)) &&
                     (!has_next || x_later)) begin
          st_d  = StScan;
          go_up = 1'b1;
          up_p  = i_q + CntW'(1);
        end else if (!has_next) begin
          st_d    = StNoPlace;
          state_d = SFin;
        end else begin
          cur_d     = x;
          i_d       = i_q + CntW'(1);
          req.re    = 1'b1;
          req.raddr = AddrW'(i_q + CntW'(2));
        end
      end

      SShUp: begin
        // move slot k to k+1, tail first; each slot is written in the cycle after its read
        if (pend_q) begin
          req.we    = 1'b1;
          req.waddr = pend_addr_q + AddrW'(1);
          req.wdata = mem_rdata_i;
        end
        if (!rd_done_q) begin
          req.re      = 1'b1;
          req.raddr   = AddrW'(k_q);
          pend_d      = 1'b1;
          pend_addr_d = AddrW'(k_q);
          if (k_q == p_q) begin
            rd_done_d = 1'b1;
          end else begin
            k_d = k_q - CntW'(1);
          end
        end else begin
          pend_d  = 1'b0;
          state_d = SWrite;
        end
      end

      SWrite: begin
        req.we    = 1'b1;
        req.waddr = AddrW'(p_q);
        req.wdata = ev_q;
        cnt_d     = cnt_q + CntW'(1);
        state_d   = SFin;
      end

      SPopRd: begin
        pop_d   = mem_rdata_i;
        popv_d  = 1'b1;
        go_down = 1'b1;
        down_s  = CntW'(1);
      end

      SShDn: begin
        // move slot k to k-1, head first
        if (pend_q) begin
          req.we    = 1'b1;
          req.waddr = pend_addr_q - AddrW'(1);
          req.wdata = mem_rdata_i;
        end
        if (!rd_done_q) begin
          req.re      = 1'b1;
          req.raddr   = AddrW'(k_q);
          pend_d      = 1'b1;
          pend_addr_d = AddrW'(k_q);
          rd_done_d   = (k_q == (cnt_q - CntW'(1)));
          k_d         = k_q + CntW'(1);
        end else begin
          pend_d  = 1'b0;
          cnt_d   = cnt_q - CntW'(1);
          state_d = SFin;
        end
      end

      SFin: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase

    if (go_up) begin
      p_d    = up_p;
      pend_d = 1'b0;
      if (up_p == cnt_q) begin
        state_d = SWrite;
      end else begin
        k_d       = cnt_q - CntW'(1);
        rd_done_d = 1'b0;
        state_d   = SShUp;
      end
    end
    if (go_down) begin
      k_d       = down_s;
      pend_d    = 1'b0;
      rd_done_d = (down_s >= cnt_q);
      state_d   = SShDn;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      rd_done_q <= 1'b0;
      popv_q    <= 1'b0;
      st_q      <= StPlaced;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      rd_done_q <= rd_done_d;
      popv_q    <= popv_d;
      st_q      <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q         <= k_d;
    p_q         <= p_d;
    i_q         <= i_d;
    pend_addr_q <= pend_addr_d;
    cur_q       <= cur_d;
    ev_q        <= ev_d;
    pop_q       <= pop_d;
  end

  assign mem_req_o   = req;
  assign res_valid_o = (state_q == SFin);
  assign res_o       = '{status: st_q, out_valid: popv_q, popped: pop_q,
                         occupancy: OccW'(cnt_q)};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("entry count above depth");

  a_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req.we && req.re && (req.waddr == req.raddr)))
    else $error("read and write hit the same slot");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("insert write did not grow the queue");

  a_pop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && popv_q) |-> (st_q == StPlaced))
    else $error("popped beat with failure status");
`endif

endmodule

`default_nettype wire

[hw/rtl/timed_event_queue.sv]
// Timed event queue: time-sorted store of (time, type, port) events with tie ordering.
// One command at a time. Insert checks the head, then the tail, then scans from
// the head one slot per cycle, then shifts the slots behind the insertion point
// up one per cycle. Scan length plus shifted entries never exceeds the count.
// Pop and delete shift the slots behind the removed one down one per cycle.
// These passes are set by the single read port and single write port of the
// slot memory, whose read data is registered. Full, empty and bad-position
// answers go straight to the result without a slot store access. A finished
// result sits in an output register, so a new command is taken while it waits.
// tie_tolerance is written through cfg_we_i/cfg_wdata_i; the user must do so
// only while idle, as the block does not enforce it; reset value 1.
// Depends on tevq_pkg, tevq_if, tevq_mem and tevq_ctrl.
`default_nettype none

module timed_event_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tevq_pkg::TolW-1:0] cfg_wdata_i,
  tevq_in_if.sink                   evt_i,
  tevq_out_if.source                res_o
);
  import tevq_pkg::*;

  logic [TolW-1:0] tol_q;
  mem_req_t        mem_req;
  entry_t          mem_rdata;
  logic            res_valid, res_ready;
  res_t            res;
  logic            out_valid_q;
  res_t            out_q;

  // tie tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolW'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  tevq_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  tevq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_i       (tol_q),
    .evt_i       (evt_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result beat register; refills in the cycle it drains
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.status    = out_q.status;
  assign res_o.out_valid = out_q.out_valid;
  assign res_o.out_time  = out_q.popped.ev_time;
  assign res_o.out_type  = out_q.popped.ev_type;
  assign res_o.out_port  = out_q.popped.ev_port;
  assign res_o.occupancy = out_q.occupancy;

endmodule

`default_nettype wire

[tb/tb_timed_event_queue.sv]
`timescale 1ns / 1ps
// Self-checking testbench for timed_event_queue: directed and random command beats
// are checked against an in-bench queue model. Depends on tevq_pkg, tevq_if and the RTL.
`default_nettype none

module tb_timed_event_queue;
  import tevq_pkg::*;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [TolW-1:0] cfg_wdata_i;

  tevq_in_if  evt ();
  tevq_out_if res ();

  timed_event_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .evt_i      (evt),
    .res_o      (res)
  );

  // ---------------------------------------------------------------------------
  // Queue model: sorted slots with the head at index 0, plus the tie window.
  // ---------------------------------------------------------------------------
  entry_t          slots [QueueDepth];
  int unsigned     held;
  logic [TolW-1:0] tie_tol;

  res_t        pending_results [$];
  int unsigned mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [TimeW-1:0] cluster_base;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void slot_insert(int unsigned idx, entry_t e);
    if (idx > held || held >= QueueDepth) return;
    for (int k = held; k > idx; k--) slots[k] = slots[k-1];
    slots[idx] = e;
    held++;
  endfunction

  function automatic void slot_remove(int unsigned idx);
    if (idx >= held) return;
    for (int k = idx; k < held - 1; k++) slots[k] = slots[k+1];
    held--;
  endfunction

  function automatic logic within_tol(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d < {16'd0, tie_tol};
  endfunction

  // Where a new event lands. Head and tail first, then a scan that orders
  // near-equal times by their kind codes.
  function automatic status_e place_event(entry_t e);
    int unsigned      n;
    logic             has_next;
    logic             near;
    logic [TimeW-1:0] nxt;
    logic [TypeW-1:0] ety;
    n = held;
    if (n >= QueueDepth) return StFull;
    if (n == 0 || slots[0].ev_time > e.ev_time) begin
      slot_insert(0, e);
      return StPlaced;
    end
    if (slots[n-1].ev_time < e.ev_time) begin
      slot_insert(n, e);
      return StPlaced;
    end
    for (int unsigned i = 0; i < n; i++) begin
      has_next = (i + 1 < n);
      ety      = slots[i].ev_type;
      near     = within_tol(slots[i].ev_time, e.ev_time);
      nxt      = has_next ? slots[i+1].ev_time : '0;
      if (has_next && ((slots[i].ev_time < e.ev_time && nxt > e.ev_time) ||
                       (nxt > e.ev_time && near))) begin
        slot_insert(i + 1, e);
        return StScan;
      end
      if (near) begin
        if (ety == e.ev_type) begin
          // same kind: 0, 1 and 3 are duplicates, anything else queues behind
          if (e.ev_type inside {EvTy0, EvTy1, EvTy3}) return StDup;
          slot_insert(i + 1, e);
          return StScan;
        end
        if (e.ev_type == EvTy4 || e.ev_type == EvTy0 ||
            (e.ev_type == EvTy2 && ety != EvTy0) ||
            (e.ev_type == EvTy1 && ety == EvTy3)) begin
          slot_insert(i, e);
          return StScan;
        end
        if ((e.ev_type == EvTy1 || e.ev_type == EvTy3) && (!has_next || nxt > e.ev_time))
        begin
          slot_insert(i + 1, e);
          return StScan;
        end
      end
    end
    return StNoPlace;  // fell off the tail
  endfunction

  function automatic res_t apply_command(logic [CmdW-1:0] c, entry_t e, logic [PosW-1:0] pos);
    res_t r;
    r = '0;
    r.status = StPlaced;
    case (c)
      CmdInsert: r.status = place_event(e);
      CmdPop: begin
        if (held == 0) r.status = StEmpty;
        else begin
          r.out_valid = 1'b1;
          r.popped    = slots[0];
          slot_remove(0);
        end
      end
      CmdDelete: begin
        if (held == 0) r.status = StEmpty;
        else if (pos >= held) r.status = StBadPos;
        else slot_remove(pos);
      end
      default: r.status = StPlaced;  // nop
    endcase
    r.occupancy = held[OccW-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------
  task automatic send_beat(logic [CmdW-1:0] c, logic [TimeW-1:0] t, logic [TypeW-1:0] ty,
                           logic [PortW-1:0] pt, logic [PosW-1:0] pos);
    entry_t e;
    int     gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.cmd        <= c;
    evt.event_time <= t;
    evt.event_type <= ty;
    evt.event_port <= pt;
    evt.position   <= pos;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
    e.ev_time = t;
    e.ev_type = ty;
    e.ev_port = pt;
    pending_results.push_back(apply_command(c, e, pos));
  endtask

  task automatic insert_ev(logic [TimeW-1:0] t, logic [TypeW-1:0] ty);
    send_beat(CmdInsert, t, ty, 16'($urandom), 6'($urandom));
  endtask

  // Drain, then write the tie window while nothing is in flight.
  task automatic set_tolerance(logic [TolW-1:0] v);
    evt.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tie_tol      = v;
  endtask

  task automatic drain_queue();
    while (held != 0) send_beat(CmdPop, '0, '0, '0, '0);
  endtask

  // Empty-queue answers, head/tail placement, bad positions, nop, field extremes.
  task automatic test_basic_commands();
    send_beat(CmdPop, '0, '0, '0, '0);
    send_beat(CmdDelete, '0, '0, '0, 6'd63);
    insert_ev(32'd1000, EvTy2);
    send_beat(CmdDelete, '0, '0, '0, '0);  // only entry removed
    insert_ev(32'd1000, EvTy2);
    insert_ev(32'd0, EvTy0);               // new head
    send_beat(CmdInsert, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 6'd0);  // new tail
    insert_ev(32'd500, EvTy1);             // strictly between
    send_beat(CmdDelete, '0, '0, '0, 6'd4);   // at count
    send_beat(CmdDelete, '0, '0, '0, 6'd63);
    send_beat(CmdNop, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 6'd63);
    send_beat(CmdDelete, '0, '0, '0, 6'd1);
    drain_queue();
    send_beat(CmdPop, '0, '0, '0, '0);
  endtask

  // Equal-time ties for every kind pairing, with the tail entry at the same time.
  // Code 5 stands in for the codes that follow only the generic rules.
  task automatic test_tie_rules();
    for (int a = 0; a < 6; a++) begin
      for (int b = 0; b < 6; b++) begin
        insert_ev(32'd100, 3'(a));
        insert_ev(32'd200, 3'(a));
        insert_ev(32'd200, 3'(b));
        insert_ev(32'd100, 3'(b));
        drain_queue();
      end
    end
  endtask

  task automatic test_full_queue();
    for (int k = 0; k < QueueDepth; k++) insert_ev(32'(k * 3), 3'($urandom_range(0, 4)));
    insert_ev(32'd10, EvTy4);
    insert_ev(32'hFFFF_FFFF, EvTy2);
    send_beat(CmdDelete, '0, '0, '0, 6'd63);  // last slot
    send_beat(CmdDelete, '0, '0, '0, 6'd0);
    drain_queue();
  endtask

  task automatic random_beat();
    int               r;
    logic [TimeW-1:0] t;
    logic [TypeW-1:0] ty;
    logic [PosW-1:0]  pos;
    r = $urandom_range(99);
    if ($urandom_range(49) == 0) cluster_base = $urandom;
    ty = ($urandom_range(99) < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
    if (r < 58) begin
      case ($urandom_range(9))
        0:       t = $urandom;
        1:       t = ($urandom_range(1)) ? 32'd0 : 32'hFFFF_FFFF;
        default: t = cluster_base + $urandom_range(0, 40);
      endcase
      send_beat(CmdInsert, t, ty, 16'($urandom), 6'($urandom));
    end else if (r < 76) begin
      send_beat(CmdPop, $urandom, ty, 16'($urandom), 6'($urandom));
    end else if (r < 96) begin
      pos = ($urandom_range(1) && held > 0) ? 6'($urandom_range(0, held - 1)) : 6'($urandom);
      send_beat(CmdDelete, $urandom, ty, 16'($urandom), pos);
    end else begin
      send_beat(CmdNop, $urandom, ty, 16'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_random(int beats, int s_idle, int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (beats) random_beat();
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    res.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", res.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (res.status != want.status) report_mismatch("status", res.status, want.status);
        if (res.out_valid != want.out_valid)
          report_mismatch("out_valid", res.out_valid, want.out_valid);
        if (res.out_time != want.popped.ev_time)
          report_mismatch("out_time", res.out_time, want.popped.ev_time);
        if (res.out_type != want.popped.ev_type)
          report_mismatch("out_type", res.out_type, want.popped.ev_type);
        if (res.out_port != want.popped.ev_port)
          report_mismatch("out_port", res.out_port, want.popped.ev_port);
        if (res.occupancy != want.occupancy)
          report_mismatch("occupancy", res.occupancy, want.occupancy);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    evt.valid      = 1'b0;
    evt.cmd        = CmdNop;
    evt.event_time = '0;
    evt.event_type = '0;
    evt.event_port = '0;
    evt.position   = '0;
    res.ready      = 1'b0;
    held           = 0;
    tie_tol        = 16'd1;
    mismatches     = 0;
    send_idle_pct  = 31;
    recv_idle_pct  = 71;
    cluster_base   = $urandom;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_tie_rules();
    test_full_queue();
    test_random(120, 31, 71);

    set_tolerance(16'd0);
    test_random(90, 71, 31);

    set_tolerance(16'hFFFF);
    test_random(90, 71, 31);
    drain_queue();

    set_tolerance(16'd8);
    test_random(130, 0, 0);

    evt.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) $display("** timed_event_queue: PASSED **");
    else $display("** timed_event_queue: FAILED **");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("** timed_event_queue: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/tevq_pkg.sv
hw/rtl/tevq_if.sv
hw/rtl/tevq_mem.sv
hw/rtl/tevq_ctrl.sv
hw/rtl/timed_event_queue.sv
tb/tb_timed_event_queue.sv
